// ----- src/twhm_pkg.sv -----
`timescale 1ns / 1ps
// twhm_pkg: widths, constants, register codes and helper functions
// for the three-wheel holonomic mixer core; no dependencies

package twhm_pkg;

	localparam int unsigned DISTANCE_WIDTH_DEF = 24;

	localparam int unsigned CMD_W   = 16;
	localparam int unsigned GAIN_W  = 16;
	localparam int unsigned SPEED_W = 16;
	localparam int unsigned DISP_W  = 25;
	localparam int unsigned MIX_W   = 48;
	localparam int unsigned MAG_W   = 47;
	localparam int unsigned QUO_W   = 15;
	localparam int unsigned SQ20_W  = 20;
	localparam int unsigned CFG_IDX_W = 8;

	// one restoring step per quotient bit
	localparam int unsigned DIV_STAGES = QUO_W;

	localparam int unsigned OUT_W  = 3 * SPEED_W + 2 * DISP_W;
	localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8;

	localparam logic [GAIN_W-1:0] X_GAIN_RST = 16'd45875;
	localparam logic [GAIN_W-1:0] Y_GAIN_RST = 16'd44564;

	// sqrt(3)/2 in Q0.30 and Q0.20
	localparam logic [29:0]       SQ3H_Q30 = 30'd929887697;
	localparam logic [SQ20_W-1:0] SQ3H_Q20 = 20'd908093;

	// unity in Q.42
	localparam logic [MAG_W-1:0] ONE_Q42 = 47'h400_0000_0000;

	localparam logic [63:0] DISP_POS_LIM = 64'd16777215;
	localparam logic [63:0] DISP_NEG_LIM = 64'd16777216;

	localparam int unsigned LANE_R = 0;
	localparam int unsigned LANE_L = 1;
	localparam int unsigned LANE_B = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_GAIN = 8'd0,
		REG_Y_GAIN = 8'd1
	} reg_idx_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic [QUO_W-1:0] raw;
	} wheel_t;

	function automatic logic [MAG_W-1:0] mix_mag(input logic signed [MIX_W-1:0] v);
		logic signed [MIX_W-1:0] n;
		n = -v;
		mix_mag = v[MIX_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
	endfunction

	function automatic logic [DISP_W-1:0] sat_disp(input logic neg, input logic [63:0] m);
		logic [DISP_W-1:0] lim;
		if (neg) begin
			lim = (m > DISP_NEG_LIM) ? DISP_NEG_LIM[DISP_W-1:0] : m[DISP_W-1:0];
			sat_disp = -lim;
		end else begin
			sat_disp = (m > DISP_POS_LIM) ? DISP_POS_LIM[DISP_W-1:0] : m[DISP_W-1:0];
		end
	endfunction

	// one restoring division step, first step compares without a shift
	function automatic wheel_t div_step(input wheel_t w, input logic [MAG_W-1:0] d,
		input logic first);
		logic [MAG_W:0] sh;
		logic [MAG_W:0] diff;
		logic           ge;
		wheel_t         o;
		o    = w;
		sh   = first ? {1'b0, w.rem} : {w.rem, 1'b0};
		diff = sh - {1'b0, d};
		ge   = sh >= {1'b0, d};
		o.rem = ge ? diff[MAG_W-1:0] : sh[MAG_W-1:0];
		o.quo = {w.quo[QUO_W-2:0], ge};
		return o;
	endfunction

	function automatic logic [SPEED_W-1:0] wheel_speed(input wheel_t w, input logic scale);
		logic [SPEED_W-1:0] q;
		q = SPEED_W'(scale ? w.quo : w.raw);
		wheel_speed = w.neg ? -q : q;
	endfunction

endpackage

// ----- src/three_wheel_holonomic_mixer_core.sv -----
`timescale 1ns / 1ps
// three_wheel_holonomic_mixer_core: kiwi drive wheel mixing with normalization
// and encoder displacement; depends on twhm_pkg

// Takes one word per clock when the output side keeps up; each word gives
// exactly one result word (three front stages, a max/scale stage, a 15-stage
// restoring divider with one quotient bit per stage, and an output register).
// The divider sets the depth. Each stage holds its word until the next has
// room, so bubbles close up and an output stall only stops stages behind a
// full one. The user must write gains through the cfg port only while no
// word is in flight; the block does not enforce it. A write acts next cycle.

module three_wheel_holonomic_mixer_core #(
	parameter int unsigned DISTANCE_WIDTH = twhm_pkg::DISTANCE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [twhm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [twhm_pkg::GAIN_W-1:0]         cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// forward_cmd, side_cmd, rotate_cmd, right_distance, left_distance,
	// back_distance, zero fill
	input  logic [((3 * twhm_pkg::CMD_W + 3 * DISTANCE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// right_speed, left_speed, back_speed, displacement_x, displacement_y,
	// zero fill
	output logic [twhm_pkg::OUT_TW-1:0]         m_tdata,
	// scaled
	output logic                                m_tuser
);

	localparam int unsigned DW   = DISTANCE_WIDTH;
	localparam int unsigned CW   = twhm_pkg::CMD_W;
	localparam int unsigned MXW  = twhm_pkg::MIX_W;
	localparam int unsigned MGW  = twhm_pkg::MAG_W;
	localparam int unsigned GW   = twhm_pkg::GAIN_W;
	localparam int unsigned SW   = twhm_pkg::SPEED_W;
	localparam int unsigned DSW  = twhm_pkg::DISP_W;
	localparam int unsigned QW   = twhm_pkg::QUO_W;
	localparam int unsigned S20W = twhm_pkg::SQ20_W;
	localparam int unsigned NDIV = twhm_pkg::DIV_STAGES;
	localparam int unsigned PAD  = twhm_pkg::OUT_TW - twhm_pkg::OUT_W;

	typedef struct packed {
		twhm_pkg::wheel_t [2:0] wh;
		logic [MGW-1:0]         maxm;
		logic                   scale;
		logic [DSW-1:0]         disp_x;
		logic [DSW-1:0]         disp_y;
		logic [DW+S20W-1:0]     pa;
		logic [S20W-1:0]        pb;
		logic [DW:0]            py;
		logic                   py_neg;
	} div_t;

	// configuration

	logic [GW-1:0] x_gain_q;
	logic [GW-1:0] y_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_gain_q <= twhm_pkg::X_GAIN_RST;
			y_gain_q <= twhm_pkg::Y_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				twhm_pkg::REG_X_GAIN: x_gain_q <= cfg_data;
				twhm_pkg::REG_Y_GAIN: y_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake chain

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	logic dv_v   [0:NDIV];
	logic dv_rdy [0:NDIV];
	logic out_valid_q;
	logic out_rdy;

	assign out_rdy = !out_valid_q || m_tready;
	assign rdy_s3  = !v_s3 || dv_rdy[0];
	assign rdy_s2  = !v_s2 || rdy_s3;
	assign rdy_s1  = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign m_tvalid = out_valid_q;

	// stage 1: sideways product and distance differences

	logic signed [CW-1:0] in_x, in_y, in_z;
	logic signed [DW-1:0] in_dr, in_dl, in_db;
	logic signed [CW+30:0] ys_c;
	logic signed [DW+1:0]  d2_c;
	logic signed [DW:0]    dd_c;

	assign in_x  = s_tdata[0 +: CW];
	assign in_y  = s_tdata[CW +: CW];
	assign in_z  = s_tdata[2*CW +: CW];
	assign in_dr = s_tdata[3*CW +: DW];
	assign in_dl = s_tdata[3*CW+DW +: DW];
	assign in_db = s_tdata[3*CW+2*DW +: DW];

	assign ys_c = (CW+31)'(in_y) * (CW+31)'($signed({1'b0, twhm_pkg::SQ3H_Q30}));
	assign d2_c = (DW+2)'(in_db) + (DW+2)'(in_db) - (DW+2)'(in_dl) - (DW+2)'(in_dr);
	assign dd_c = (DW+1)'(in_dr) - (DW+1)'(in_dl);

	logic signed [CW-1:0]   x_s1, z_s1;
	logic signed [CW+30:0]  ys_s1;
	logic signed [DW+1:0]   d2_s1;
	logic signed [DW:0]     dd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			x_s1  <= in_x;
			z_s1  <= in_z;
			ys_s1 <= ys_c;
			d2_s1 <= d2_c;
			dd_s1 <= dd_c;
		end
	end

	// stage 2: wheel sums in Q.42, distance magnitudes

	logic signed [MXW-1:0] xw_c, zw_c, ysw_c;
	logic signed [MXW-1:0] r_c, l_c, b_c;
	logic signed [DW+1:0]  d2n_c;
	logic signed [DW:0]    ddn_c;

	assign xw_c  = MXW'(x_s1);
	assign zw_c  = MXW'(z_s1);
	assign ysw_c = MXW'(ys_s1);
	assign r_c   = (xw_c <<< 29) - ysw_c + (zw_c <<< 30);
	assign l_c   = (xw_c <<< 29) + ysw_c + (zw_c <<< 30);
	assign b_c   = (zw_c <<< 30) - (xw_c <<< 30);
	assign d2n_c = -d2_s1;
	assign ddn_c = -dd_s1;

	logic signed [MXW-1:0] r_s2, l_s2, b_s2;
	logic                  d2_neg_s2, dd_neg_s2;
	logic [DW:0]           d2_mag_s2;
	logic [DW-1:0]         dd_mag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			r_s2      <= r_c;
			l_s2      <= l_c;
			b_s2      <= b_c;
			d2_neg_s2 <= d2_s1[DW+1];
			d2_mag_s2 <= d2_s1[DW+1] ? d2n_c[DW:0] : d2_s1[DW:0];
			dd_neg_s2 <= dd_s1[DW];
			dd_mag_s2 <= dd_s1[DW] ? ddn_c[DW-1:0] : dd_s1[DW-1:0];
		end
	end

	// stage 3: wheel magnitudes, gain products

	logic [DW+GW:0]   px_prod_c;
	logic [DW+GW-1:0] p_c;

	assign px_prod_c = (DW+GW+1)'(d2_mag_s2) * (DW+GW+1)'(x_gain_q);
	assign p_c       = (DW+GW)'(dd_mag_s2) * (DW+GW)'(y_gain_q);

	logic [MGW-1:0]   rm_s3, lm_s3, bm_s3;
	logic             rn_s3, ln_s3, bn_s3;
	logic [DW+GW:0]   px_prod_s3;
	logic [DW+GW-1:0] p_s3;
	logic             d2_neg_s3, dd_neg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			rm_s3      <= twhm_pkg::mix_mag(r_s2);
			lm_s3      <= twhm_pkg::mix_mag(l_s2);
			bm_s3      <= twhm_pkg::mix_mag(b_s2);
			rn_s3      <= r_s2[MXW-1];
			ln_s3      <= l_s2[MXW-1];
			bn_s3      <= b_s2[MXW-1];
			px_prod_s3 <= px_prod_c;
			p_s3       <= p_c;
			d2_neg_s3  <= d2_neg_s2;
			dd_neg_s3  <= dd_neg_s2;
		end
	end

	// stage 4: largest magnitude, scale test, x displacement, y partials

	logic [MGW-1:0]        maxrl_c, maxm_c;
	logic [DW-1:0]         px_c;
	logic [DW+S20W-1:0]    pa_c;
	logic [GW+S20W-1:0]    pbp_c;
	div_t                  mid_c;

	assign maxrl_c = (lm_s3 > rm_s3) ? lm_s3 : rm_s3;
	assign maxm_c  = (bm_s3 > maxrl_c) ? bm_s3 : maxrl_c;
	assign px_c    = px_prod_s3[DW+GW:17];
	assign pa_c    = (DW+S20W)'(p_s3[DW+GW-1:GW]) * (DW+S20W)'(twhm_pkg::SQ3H_Q20);
	assign pbp_c   = (GW+S20W)'(p_s3[GW-1:0]) * (GW+S20W)'(twhm_pkg::SQ3H_Q20);

	always_comb begin
		mid_c = '0;
		mid_c.wh[twhm_pkg::LANE_R].neg = rn_s3;
		mid_c.wh[twhm_pkg::LANE_R].rem = rm_s3;
		mid_c.wh[twhm_pkg::LANE_R].raw = rm_s3[28 +: QW];
		mid_c.wh[twhm_pkg::LANE_L].neg = ln_s3;
		mid_c.wh[twhm_pkg::LANE_L].rem = lm_s3;
		mid_c.wh[twhm_pkg::LANE_L].raw = lm_s3[28 +: QW];
		mid_c.wh[twhm_pkg::LANE_B].neg = bn_s3;
		mid_c.wh[twhm_pkg::LANE_B].rem = bm_s3;
		mid_c.wh[twhm_pkg::LANE_B].raw = bm_s3[28 +: QW];
		mid_c.maxm   = maxm_c;
		mid_c.scale  = maxm_c > twhm_pkg::ONE_Q42;
		mid_c.disp_x = twhm_pkg::sat_disp(d2_neg_s3, 64'(px_c));
		mid_c.pa     = pa_c;
		mid_c.pb     = pbp_c[GW+S20W-1:GW];
		mid_c.py_neg = dd_neg_s3;
	end

	// divider pipeline, dv_s[0] is stage 4

	div_t dv_s   [0:NDIV];
	div_t dv_nxt [1:NDIV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (dv_rdy[0]) begin
			dv_v[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_rdy[0] && v_s3) begin
			dv_s[0] <= mid_c;
		end
	end

	for (genvar k = 0; k <= NDIV; k++) begin : g_rdy
		if (k == NDIV) begin : g_last
			assign dv_rdy[k] = !dv_v[k] || out_rdy;
		end else begin : g_mid
			assign dv_rdy[k] = !dv_v[k] || dv_rdy[k+1];
		end
	end

	for (genvar k = 1; k <= NDIV; k++) begin : g_div
		logic [DW+S20W:0] pysum;

		assign pysum = {1'b0, dv_s[k-1].pa} + (DW+S20W+1)'(dv_s[k-1].pb);

		always_comb begin
			dv_nxt[k] = dv_s[k-1];
			dv_nxt[k].wh[twhm_pkg::LANE_R] = twhm_pkg::div_step(
				dv_s[k-1].wh[twhm_pkg::LANE_R], dv_s[k-1].maxm, k == 1);
			dv_nxt[k].wh[twhm_pkg::LANE_L] = twhm_pkg::div_step(
				dv_s[k-1].wh[twhm_pkg::LANE_L], dv_s[k-1].maxm, k == 1);
			dv_nxt[k].wh[twhm_pkg::LANE_B] = twhm_pkg::div_step(
				dv_s[k-1].wh[twhm_pkg::LANE_B], dv_s[k-1].maxm, k == 1);
			// y displacement finishes in the first two divider stages
			if (k == 1) begin
				dv_nxt[k].py = pysum[DW+S20W:S20W];
			end
			if (k == 2) begin
				dv_nxt[k].disp_y = twhm_pkg::sat_disp(dv_s[k-1].py_neg,
					64'(dv_s[k-1].py));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k] <= 1'b0;
			end else if (dv_rdy[k]) begin
				dv_v[k] <= dv_v[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (dv_rdy[k] && dv_v[k-1]) begin
				dv_s[k] <= dv_nxt[k];
			end
		end
	end

	// output register

	logic [SW-1:0] rs_c, ls_c, bs_c;

	assign rs_c = twhm_pkg::wheel_speed(dv_s[NDIV].wh[twhm_pkg::LANE_R], dv_s[NDIV].scale);
	assign ls_c = twhm_pkg::wheel_speed(dv_s[NDIV].wh[twhm_pkg::LANE_L], dv_s[NDIV].scale);
	assign bs_c = twhm_pkg::wheel_speed(dv_s[NDIV].wh[twhm_pkg::LANE_B], dv_s[NDIV].scale);

	logic [twhm_pkg::OUT_TW-1:0] out_data_q;
	logic                        out_scaled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_rdy) begin
			out_valid_q <= dv_v[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && dv_v[NDIV]) begin
			out_data_q   <= {PAD'(0), dv_s[NDIV].disp_y, dv_s[NDIV].disp_x,
				bs_c, ls_c, rs_c};
			out_scaled_q <= dv_s[NDIV].scale;
		end
	end

	assign m_tdata = out_data_q;
	assign m_tuser = out_scaled_q;

endmodule

// ----- verif/three_wheel_holonomic_mixer_core_test.sv -----
`timescale 1ns / 1ps
// three_wheel_holonomic_mixer_core_test: self-checking bench for the kiwi drive mixer core,
// predicting wheel speeds, scale flag and displacements per word; depends on twhm_pkg

module three_wheel_holonomic_mixer_core_test;

	localparam int unsigned CW    = twhm_pkg::CMD_W;
	localparam int unsigned GW    = twhm_pkg::GAIN_W;
	localparam int unsigned SW    = twhm_pkg::SPEED_W;
	localparam int unsigned DSW   = twhm_pkg::DISP_W;
	localparam int unsigned IW    = twhm_pkg::CFG_IDX_W;
	localparam int unsigned DW    = twhm_pkg::DISTANCE_WIDTH_DEF;
	localparam int unsigned IN_TW = ((3 * CW + 3 * DW + 7) / 8) * 8;

	localparam logic [IW-1:0] REG_UNMAPPED_LO = 8'd2;
	localparam logic [IW-1:0] REG_UNMAPPED_HI = 8'hFF;

	localparam logic [GW-1:0] X_GAIN_DEFAULT = 16'd45875;
	localparam logic [GW-1:0] Y_GAIN_DEFAULT = 16'd44564;
	localparam logic [GW-1:0] GAIN_TOP       = 16'hFFFF;

	localparam logic [CW-1:0] CMD_MAX   = 16'h7FFF;
	localparam logic [CW-1:0] CMD_MIN   = 16'h8000;
	localparam logic [CW-1:0] CMD_UNITY = 16'd4096;
	localparam logic [DW-1:0] DIST_MAX  = {1'b0, {(DW - 1){1'b1}}};
	localparam logic [DW-1:0] DIST_MIN  = {1'b1, {(DW - 1){1'b0}}};

	localparam longint          SQ3H_MIX   = 929887697;
	localparam longint unsigned SQ3H_DISP  = 908093;
	localparam longint unsigned UNITY_Q42  = 64'd1 << 42;
	localparam longint          DISP_TOP   = 16777215;
	localparam longint          DISP_FLOOR = -16777216;

	localparam int PIPE_LATENCY   = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 100;
	localparam int PHASE_ITEMS    = 300;

	typedef struct packed {
		logic signed [CW-1:0] fwd;
		logic signed [CW-1:0] side;
		logic signed [CW-1:0] rot;
		logic signed [DW-1:0] right;
		logic signed [DW-1:0] left;
		logic signed [DW-1:0] back;
	} drive_cmd_t;

	typedef struct packed {
		logic [SW-1:0]  right_spd;
		logic [SW-1:0]  left_spd;
		logic [SW-1:0]  back_spd;
		logic           scaled;
		logic [DSW-1:0] disp_x;
		logic [DSW-1:0] disp_y;
	} wheel_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [IW-1:0]                 cfg_index;
	logic [GW-1:0]                 cfg_data;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [IN_TW-1:0]              s_tdata;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [twhm_pkg::OUT_TW-1:0]   m_tdata;
	logic                          m_tuser;

	logic [GW-1:0]     x_gain_now;
	logic [GW-1:0]     y_gain_now;
	wheel_result_t     drive_expect[$];
	int                mismatches = 0;
	int                idle_cycles = 0;
	int                hold_len;
	bit                src_bursts;
	bit                sink_bursts;

	three_wheel_holonomic_mixer_core #(
		.DISTANCE_WIDTH(DW)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned abs64(input longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic logic [SW-1:0] wheel_drive(input longint v,
		input longint unsigned peak, input bit norm);
		longint unsigned m;
		longint unsigned q;
		m = abs64(v);
		q = norm ? (m << 14) / peak : (m >> 28);
		return (v < 0) ? SW'(-q) : SW'(q);
	endfunction

	function automatic logic [DSW-1:0] clamp_disp(input bit neg, input longint unsigned m);
		longint v;
		v = neg ? -longint'(m) : longint'(m);
		if (v > DISP_TOP)
			v = DISP_TOP;
		else if (v < DISP_FLOOR)
			v = DISP_FLOOR;
		return DSW'(v);
	endfunction

	// wheel mixing in Q.42, normalize when the largest wheel exceeds one
	function automatic wheel_result_t predict_drive(input drive_cmd_t c);
		longint          xv, yv, zv;
		longint          rq, lq, bq;
		longint          d2, dd;
		longint unsigned peak, prod, py;
		wheel_result_t   res;
		xv = c.fwd;
		yv = c.side;
		zv = c.rot;
		rq = (xv <<< 29) - yv * SQ3H_MIX + (zv <<< 30);
		lq = (xv <<< 29) + yv * SQ3H_MIX + (zv <<< 30);
		bq = (zv <<< 30) - (xv <<< 30);
		peak = abs64(rq);
		if (abs64(lq) > peak)
			peak = abs64(lq);
		if (abs64(bq) > peak)
			peak = abs64(bq);
		res.scaled    = (peak > UNITY_Q42);
		res.right_spd = wheel_drive(rq, peak, res.scaled);
		res.left_spd  = wheel_drive(lq, peak, res.scaled);
		res.back_spd  = wheel_drive(bq, peak, res.scaled);

		d2 = 2 * longint'(c.back) - longint'(c.left) - longint'(c.right);
		res.disp_x = clamp_disp(d2 < 0, (abs64(d2) * x_gain_now) >> 17);

		dd = longint'(c.right) - longint'(c.left);
		prod = abs64(dd) * y_gain_now;
		py = ((prod >> 16) * SQ3H_DISP + (((prod & 64'hFFFF) * SQ3H_DISP) >> 16)) >> 20;
		res.disp_y = clamp_disp(dd < 0, py);
		return res;
	endfunction

	function automatic drive_cmd_t make_cmd(input logic [CW-1:0] f, input logic [CW-1:0] s,
		input logic [CW-1:0] r, input logic [DW-1:0] dr, input logic [DW-1:0] dl,
		input logic [DW-1:0] db);
		drive_cmd_t c;
		c.fwd   = f;
		c.side  = s;
		c.rot   = r;
		c.right = dr;
		c.left  = dl;
		c.back  = db;
		return c;
	endfunction

	function automatic logic [CW-1:0] rand_speed_cmd();
		case ($urandom_range(0, 4))
			0, 1: return CW'($urandom);
			2: return CW'($urandom_range(0, 8192) - 4096);
			3: return CW'($urandom_range(0, 2048) - 1024);
			default: begin
				case ($urandom_range(0, 4))
					0: return CMD_MAX;
					1: return CMD_MIN;
					2: return CMD_UNITY;
					3: return -CMD_UNITY;
					default: return '0;
				endcase
			end
		endcase
	endfunction

	function automatic logic [DW-1:0] rand_distance();
		case ($urandom_range(0, 3))
			0, 1: return DW'($urandom);
			2: return DW'($urandom_range(0, 2000) - 1000);
			default: begin
				case ($urandom_range(0, 3))
					0: return DIST_MAX;
					1: return DIST_MIN;
					2: return '1;
					default: return '0;
				endcase
			end
		endcase
	endfunction

	function automatic drive_cmd_t rand_cmd();
		return make_cmd(rand_speed_cmd(), rand_speed_cmd(), rand_speed_cmd(),
			rand_distance(), rand_distance(), rand_distance());
	endfunction

	// entered and left just after a falling edge
	task automatic send_word(input drive_cmd_t c);
		int gap;
		if (src_bursts && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {c.back, c.left, c.right, c.rot, c.side, c.fwd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		drive_expect.push_back(predict_drive(c));
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		repeat (count)
			send_word(rand_cmd());
	endtask

	task automatic write_reg(input logic [IW-1:0] idx, input logic [GW-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			twhm_pkg::REG_X_GAIN: x_gain_now = val;
			twhm_pkg::REG_Y_GAIN: y_gain_now = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (drive_expect.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_reset_defaults();
		send_word(make_cmd(0, 0, 0, 0, 0, 0));
		send_word(make_cmd(CMD_MAX, 0, 0, DIST_MAX, DIST_MIN, 0));
		send_word(make_cmd(CMD_MIN, 0, 0, DIST_MIN, DIST_MAX, DIST_MAX));
		send_word(make_cmd(0, CMD_MAX, 0, 0, 0, DIST_MIN));
		send_word(make_cmd(0, CMD_MIN, 0, DIST_MAX, DIST_MAX, DIST_MIN));
		send_word(make_cmd(0, 0, CMD_MAX, DIST_MIN, DIST_MIN, DIST_MAX));
		send_word(make_cmd(0, 0, CMD_MIN, 1, -1, 0));
		send_word(make_cmd(CMD_MAX, CMD_MAX, CMD_MAX, DIST_MAX, DIST_MAX, DIST_MAX));
		send_word(make_cmd(CMD_MIN, CMD_MIN, CMD_MIN, DIST_MIN, DIST_MIN, DIST_MIN));
		// largest wheel at exactly one: no normalization
		send_word(make_cmd(0, 0, CMD_UNITY, 0, 0, -1));
		send_word(make_cmd(0, 0, -CMD_UNITY, -1, 0, 0));
		send_word(make_cmd(CMD_UNITY, 0, 0, 0, -1, 0));
		send_word(make_cmd(-CMD_UNITY, 0, 0, 5, 3, 1));
		// just past one
		send_word(make_cmd(0, 0, CMD_UNITY + 1, 100, -100, 7));
		send_word(make_cmd(-CMD_UNITY - 1, 0, 0, -7, 100, 3));
		// small mixes, negative truncation toward zero
		send_word(make_cmd(1000, -800, 300, 12345, -54321, 777));
		send_word(make_cmd(-1, -1, -1, -1, -1, -1));
		send_word(make_cmd(1, 1, 1, 1, 0, 0));
		send_word(make_cmd(-1200, 1300, -400, -3, 3, -2));
		send_word(make_cmd(2000, 3000, -4000, DIST_MAX, 0, DIST_MIN));
		wait_drain();
	endtask

	task automatic test_gain_extremes();
		write_reg(twhm_pkg::REG_X_GAIN, '0);
		write_reg(twhm_pkg::REG_Y_GAIN, GAIN_TOP);
		send_random(150);
		wait_drain();
		write_reg(twhm_pkg::REG_X_GAIN, GAIN_TOP);
		write_reg(twhm_pkg::REG_Y_GAIN, '0);
		send_random(150);
		wait_drain();
		// unmapped indexes must leave both gains alone
		write_reg(REG_UNMAPPED_LO, 16'h1234);
		write_reg(REG_UNMAPPED_HI, 16'h0001);
		send_random(100);
		wait_drain();
	endtask

	task automatic test_output_hold();
		write_reg(twhm_pkg::REG_X_GAIN, X_GAIN_DEFAULT);
		write_reg(twhm_pkg::REG_Y_GAIN, Y_GAIN_DEFAULT);
		src_bursts = 1'b0;
		hold_len   = HOLD_CYCLES;
		send_random(80);
		wait_drain();
		src_bursts = 1'b1;
	endtask

	task automatic test_random_gains();
		repeat (4) begin
			write_reg(twhm_pkg::REG_X_GAIN, GW'($urandom));
			write_reg(twhm_pkg::REG_Y_GAIN, GW'($urandom));
			send_random(PHASE_ITEMS);
			wait_drain();
		end
	endtask

	task automatic test_steady_stream();
		src_bursts  = 1'b0;
		sink_bursts = 1'b0;
		write_reg(twhm_pkg::REG_X_GAIN, GW'($urandom));
		write_reg(twhm_pkg::REG_Y_GAIN, GW'($urandom));
		send_random(250);
		wait_drain();
	endtask

	// output side: random stall bursts and one long hold-off on request
	initial begin : sink_proc
		int gap;
		bit hold_done;
		hold_done = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len != 0 && !hold_done) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_done = 1'b1;
				m_tready <= 1'b1;
			end else if (sink_bursts && arst_n && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 10);
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string fname, input logic [DSW-1:0] want,
		input logic [DSW-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		wheel_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (drive_expect.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h", $time,
					m_tdata);
				mismatches++;
			end else begin
				want = drive_expect.pop_front();
				check_field("right_speed", want.right_spd, m_tdata[15:0]);
				check_field("left_speed", want.left_spd, m_tdata[31:16]);
				check_field("back_speed", want.back_spd, m_tdata[47:32]);
				check_field("scaled", want.scaled, m_tuser);
				check_field("displacement_x", want.disp_x, m_tdata[72:48]);
				check_field("displacement_y", want.disp_y, m_tdata[97:73]);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("three_wheel_holonomic_mixer_core_test: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		x_gain_now  = X_GAIN_DEFAULT;
		y_gain_now  = Y_GAIN_DEFAULT;
		hold_len    = 0;
		src_bursts  = 1'b1;
		sink_bursts = 1'b1;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_gain_extremes();
		test_output_hold();
		test_random_gains();
		test_steady_stream();

		repeat (PIPE_LATENCY + 20) @(negedge clk);
		if (mismatches == 0 && drive_expect.size() == 0) begin
			$display("three_wheel_holonomic_mixer_core_test: done, clean");
		end else begin
			$display("three_wheel_holonomic_mixer_core_test: done, errors");
		end
		$finish;
	end

endmodule
